// ===== src/mfd_pkg.sv =====
// Shared types, constants and lookup functions of the MP4 file detector.
// No dependencies; used by every module under src.
`default_nettype none
package mfd_pkg;

    localparam int HEADER_SIZE_DEF = 16;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int BRAND_BASE      = 16;
    localparam logic [31:0] MIN_BOX = 32'd8;

    // Box type codes
    localparam logic [31:0] BOX_FTYP = "ftyp";
    localparam logic [31:0] BOX_MOOV = "moov";
    localparam logic [31:0] BOX_MDAT = "mdat";
    localparam logic [31:0] BOX_FREE = "free";
    localparam logic [31:0] BOX_SKIP = "skip";
    localparam logic [31:0] BOX_WIDE = "wide";
    localparam logic [31:0] BOX_PNOT = "pnot";

    // Extension codes
    localparam logic [4:0] EXT_MP4 = 5'd0;
    localparam logic [4:0] EXT_3G2 = 5'd1;
    localparam logic [4:0] EXT_3GP = 5'd2;
    localparam logic [4:0] EXT_DVB = 5'd3;
    localparam logic [4:0] EXT_F4V = 5'd4;
    localparam logic [4:0] EXT_F4P = 5'd5;
    localparam logic [4:0] EXT_F4A = 5'd6;
    localparam logic [4:0] EXT_F4B = 5'd7;
    localparam logic [4:0] EXT_JP2 = 5'd8;
    localparam logic [4:0] EXT_JPM = 5'd9;
    localparam logic [4:0] EXT_JPX = 5'd10;
    localparam logic [4:0] EXT_M4A = 5'd11;
    localparam logic [4:0] EXT_M4B = 5'd12;
    localparam logic [4:0] EXT_M4P = 5'd13;
    localparam logic [4:0] EXT_M4V = 5'd14;
    localparam logic [4:0] EXT_MQV = 5'd15;
    localparam logic [4:0] EXT_MOV = 5'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } mfd_item_t;

    typedef struct packed {
        logic        is_file;
        logic [31:0] file_length;
        logic [4:0]  ext_code;
    } mfd_result_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } mfd_brand_t;

    function automatic mfd_brand_t mfd_brand_lookup(input logic [31:0] w);
        mfd_brand_t r;
        r.hit  = 1'b1;
        r.code = EXT_MP4;
        case (w)
            "3g2a", "3g2b", "3g2c": r.code = EXT_3G2;
            "3ge6", "3ge7", "3gg6", "3gp1", "3gp2", "3gp3", "3gp4", "3gp5",
            "3gp6", "3gs7", "KDDI": r.code = EXT_3GP;
            "dvr1", "dvt1": r.code = EXT_DVB;
            "F4V ": r.code = EXT_F4V;
            "F4P ": r.code = EXT_F4P;
            "F4A ": r.code = EXT_F4A;
            "F4B ": r.code = EXT_F4B;
            "JP2 ", "JP20", "mj2s", "mjp2": r.code = EXT_JP2;
            "jpm ": r.code = EXT_JPM;
            "jpx ": r.code = EXT_JPX;
            "M4A ": r.code = EXT_M4A;
            "M4B ": r.code = EXT_M4B;
            "M4P ": r.code = EXT_M4P;
            "M4V ", "M4VH", "M4VP": r.code = EXT_M4V;
            "mqt ": r.code = EXT_MQV;
            "qt  ": r.code = EXT_MOV;
            "avc1", "CAEP", "caqv", "CDes", "da0a", "da0b", "da1a", "da1b",
            "da2a", "da2b", "da3a", "da3b", "dmb1", "dmpf", "drc1", "dv1a",
            "dv1b", "dv2a", "dv2b", "dv3a", "dv3b", "isc2", "iso2", "isom",
            "mmp4", "mp21", "mp41", "mp42", "mp71", "MPPI", "MSNV", "NDAS",
            "NDSC", "NDSH", "NDSM", "NDSP", "NDSS", "NDXC", "NDXH", "NDXM",
            "NDXP", "NDXS", "odcf", "opf2", "opx2", "pana", "ROSS", "sdv ",
            "ssc1", "ssc2": r.code = EXT_MP4;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic mfd_known_box(input logic [31:0] w);
        return (w == BOX_FTYP) || (w == BOX_MOOV) || (w == BOX_MDAT) ||
               (w == BOX_FREE) || (w == BOX_SKIP) || (w == BOX_WIDE) ||
               (w == BOX_PNOT);
    endfunction

endpackage
`default_nettype wire

// ===== src/mfd_in_stage.sv =====
// Input register of the MP4 file detector.
// Depends on mfd_pkg for the item type.
`default_nettype none
module mfd_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_last_byte,
    input  wire logic              step,
    output logic                   item_valid,
    output mfd_pkg::mfd_item_t     item
);
    import mfd_pkg::*;

    logic      valid_reg, valid_next;
    mfd_item_t item_reg, item_next;

    // Free when empty or when the held item is consumed this cycle
    assign s_ready = !valid_reg || step;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                item_next.data_byte = s_data_byte;
                item_next.last_byte = s_last_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// ===== src/mfd_parser.sv =====
// Box parser of the MP4 file detector: one byte per step, result on the last byte.
// Depends on mfd_pkg for types, box codes and the brand lookup.
`default_nettype none
module mfd_parser #(
    parameter int HEADER_SIZE = mfd_pkg::HEADER_SIZE_DEF,
    parameter int LENGTH_BITS = mfd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire mfd_pkg::mfd_item_t item,
    output mfd_pkg::mfd_result_t    result
);
    import mfd_pkg::*;

    typedef enum logic [1:0] {PH_HEADER, PH_WALK, PH_HELD, PH_DONE} phase_t;

    localparam int PW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
    localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [PW:0] LEN_MAX_X = (PW+1)'(POS_MAX);

    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [31:0]            word_reg, word_next;
    logic [PW-1:0]          ftyp_end_reg, ftyp_end_next;
    logic [PW-1:0]          box_start_reg, box_start_next;
    logic [31:0]            box_size_reg, box_size_next;
    phase_t                 phase_reg, phase_next;
    logic [4:0]             ext_reg, ext_next;
    logic                   ext_valid_reg, ext_valid_next;
    logic                   rejected_reg, rejected_next;

    logic [PW:0]   pos_x, held_sum, walk_start;
    logic [PW-1:0] len_min;
    logic          compat_try, brand_try, is_file;
    mfd_brand_t    brand;

    assign pos_x    = (PW+1)'(pos_reg);
    assign held_sum = {1'b0, box_start_reg} + (PW+1)'(box_size_reg);
    assign brand    = mfd_brand_lookup(word_next);

    // Compatible brand: word starts on a 4-byte slot inside the ftyp box
    assign compat_try = (pos_x >= (PW+1)'(BRAND_BASE + 3)) && (pos_reg[1:0] == 2'b11) &&
                        (pos_x < ({1'b0, ftyp_end_reg} + (PW+1)'(3))) &&
                        (word_next != 32'd0) && !ext_valid_reg && !rejected_reg;
    assign brand_try  = ((pos_reg == LENGTH_BITS'(11)) && !rejected_reg) || compat_try;

    always_comb begin
        word_next      = {word_reg[23:0], item.data_byte};
        pos_next       = (pos_reg == POS_MAX) ? pos_reg : pos_reg + LENGTH_BITS'(1);
        ftyp_end_next  = ftyp_end_reg;
        box_start_next = box_start_reg;
        box_size_next  = box_size_reg;
        phase_next     = phase_reg;
        ext_next       = ext_reg;
        ext_valid_next = ext_valid_reg;
        rejected_next  = rejected_reg;

        // Header seen on the previous byte: advance past its box
        if (phase_reg == PH_HELD) begin
            phase_next     = PH_WALK;
            box_start_next = (held_sum > LEN_MAX_X) ? PW'(LEN_MAX_X) : held_sum[PW-1:0];
        end

        walk_start = {1'b0, box_start_next};
        if (pos_reg != POS_MAX) begin
            if (pos_reg == LENGTH_BITS'(3)) begin
                ftyp_end_next  = PW'(word_next);
                box_start_next = PW'(word_next);
                if (word_next < 32'(HEADER_SIZE)) begin
                    rejected_next = 1'b1;
                end
            end
            if (pos_reg == LENGTH_BITS'(7)) begin
                if (word_next != BOX_FTYP) begin
                    rejected_next = 1'b1;
                end else if (!rejected_next) begin
                    phase_next = PH_WALK;
                end
            end
            if (brand_try && brand.hit) begin
                ext_next       = brand.code;
                ext_valid_next = 1'b1;
            end
            walk_start = {1'b0, box_start_next};
            if (phase_next == PH_WALK) begin
                if (pos_x == walk_start + (PW+1)'(3)) begin
                    box_size_next = word_next;
                end else if (pos_x == walk_start + (PW+1)'(7)) begin
                    if (box_size_next < MIN_BOX || !mfd_known_box(word_next)) begin
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_HELD;
                    end
                end
            end
        end

        len_min = (box_start_next < PW'(pos_next)) ? box_start_next : PW'(pos_next);
        is_file = !rejected_next && ext_valid_next &&
                  (pos_next >= LENGTH_BITS'(HEADER_SIZE));
        result.is_file     = is_file;
        result.ext_code    = is_file ? ext_next : EXT_MP4;
        result.file_length = !is_file ? 32'd0 :
                             (len_min > PW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : len_min[31:0];
    end

    // The last byte of a stream returns everything to reset values
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last_byte)) begin
            pos_reg       <= '0;
            word_reg      <= '0;
            ftyp_end_reg  <= '0;
            box_start_reg <= '0;
            box_size_reg  <= '0;
            phase_reg     <= PH_HEADER;
            ext_reg       <= EXT_MP4;
            ext_valid_reg <= 1'b0;
            rejected_reg  <= 1'b0;
        end else if (step) begin
            pos_reg       <= pos_next;
            word_reg      <= word_next;
            ftyp_end_reg  <= ftyp_end_next;
            box_start_reg <= box_start_next;
            box_size_reg  <= box_size_next;
            phase_reg     <= phase_next;
            ext_reg       <= ext_next;
            ext_valid_reg <= ext_valid_next;
            rejected_reg  <= rejected_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/mfd_out_stage.sv =====
// Result register of the MP4 file detector.
// Depends on mfd_pkg for the result type.
`default_nettype none
module mfd_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire mfd_pkg::mfd_result_t result,
    output logic                      out_free,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_is_file,
    output logic [31:0]               m_file_length,
    output logic [4:0]                m_ext_code
);
    import mfd_pkg::*;

    logic        valid_reg, valid_next;
    mfd_result_t result_reg, result_next;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next  = valid_reg;
        result_next = result_reg;
        if (load) begin
            valid_next  = 1'b1;
            result_next = result;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        result_reg <= result_next;
    end

    assign m_valid       = valid_reg;
    assign m_is_file     = result_reg.is_file;
    assign m_file_length = result_reg.file_length;
    assign m_ext_code    = result_reg.ext_code;

endmodule
`default_nettype wire

// ===== src/mp4_file_detector.sv =====
// Top level of the MP4-family file detector: input register, box parser, result register.
// Depends on mfd_pkg, mfd_in_stage, mfd_parser and mfd_out_stage.
//
//   channel   direction  ports                                     item
//   s_        in         s_valid s_ready s_data_byte s_last_byte   one stream byte
//   m_        out        m_valid m_ready m_is_file m_file_length   one verdict per stream
//                                         m_ext_code
//
// Flow: one byte per clock while no last byte waits for the result register; m_valid
//   rises once the last byte is taken and parsed out of the input register straight into
//   the result register.
// Reset: aresetn low clears parser state and both valid flags.
// Stalls: bytes without the last flag keep flowing while a verdict waits on m_ready;
//   a last byte waits in the input register until the result register is free.
// After each verdict the parser is back at its reset state for the next stream.
`default_nettype none
module mp4_file_detector #(
    parameter int HEADER_SIZE = mfd_pkg::HEADER_SIZE_DEF,
    parameter int LENGTH_BITS = mfd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_is_file,
    output logic [31:0]      m_file_length,
    output logic [4:0]       m_ext_code
);
    import mfd_pkg::*;

    logic        item_valid;
    mfd_item_t   item;
    logic        out_free;
    logic        step;
    mfd_result_t result;

    // A byte is parsed when held and, if it ends a stream, its verdict has room
    assign step = item_valid && (!item.last_byte || out_free);

    mfd_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .step        (step),
        .item_valid  (item_valid),
        .item        (item)
    );

    mfd_parser #(
        .HEADER_SIZE (HEADER_SIZE),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .result  (result)
    );

    mfd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (step && item.last_byte),
        .result        (result),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_file     (m_is_file),
        .m_file_length (m_file_length),
        .m_ext_code    (m_ext_code)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_mp4_file_detector.sv =====
// Self-checking testbench for mp4_file_detector: drives byte streams of MP4-family files,
// broken headers and noise, and checks each verdict against an in-bench parser model or a hand-written verdict.
// Depends on mfd_pkg (types, box and extension codes) and the mp4_file_detector RTL.
`timescale 1ns / 100ps

module tb_mp4_file_detector;
    import mfd_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int                BYTES_WANTED   = 1100;
    localparam int                STREAMS_WANTED = 48;   // verdicts are one per stream
    localparam int                PRESSURE_AT    = 20;   // stream index of the hold-off phase
    localparam int                HOLD_CYCLES    = 300;
    localparam int                DRAIN_LIMIT    = 2000;
    localparam int                MAX_REPORTS    = 10;
    localparam longint unsigned   LEN_MAX        = (64'd1 << LENGTH_BITS_DEF) - 1;
    localparam int                N_BRANDS       = 84;

    // Brand word and the extension it selects: {tag[31:0], code[4:0]}
    localparam logic [36:0] BRANDS [N_BRANDS] = '{
        {"3g2a", EXT_3G2}, {"3g2b", EXT_3G2}, {"3g2c", EXT_3G2},
        {"3ge6", EXT_3GP}, {"3ge7", EXT_3GP}, {"3gg6", EXT_3GP},
        {"3gp1", EXT_3GP}, {"3gp2", EXT_3GP}, {"3gp3", EXT_3GP},
        {"3gp4", EXT_3GP}, {"3gp5", EXT_3GP}, {"3gp6", EXT_3GP},
        {"3gs7", EXT_3GP}, {"avc1", EXT_MP4}, {"CAEP", EXT_MP4},
        {"caqv", EXT_MP4}, {"CDes", EXT_MP4}, {"da0a", EXT_MP4},
        {"da0b", EXT_MP4}, {"da1a", EXT_MP4}, {"da1b", EXT_MP4},
        {"da2a", EXT_MP4}, {"da2b", EXT_MP4}, {"da3a", EXT_MP4},
        {"da3b", EXT_MP4}, {"dmb1", EXT_MP4}, {"dmpf", EXT_MP4},
        {"drc1", EXT_MP4}, {"dv1a", EXT_MP4}, {"dv1b", EXT_MP4},
        {"dv2a", EXT_MP4}, {"dv2b", EXT_MP4}, {"dv3a", EXT_MP4},
        {"dv3b", EXT_MP4}, {"dvr1", EXT_DVB}, {"dvt1", EXT_DVB},
        {"F4V ", EXT_F4V}, {"F4P ", EXT_F4P}, {"F4A ", EXT_F4A},
        {"F4B ", EXT_F4B}, {"isc2", EXT_MP4}, {"iso2", EXT_MP4},
        {"isom", EXT_MP4}, {"JP2 ", EXT_JP2}, {"JP20", EXT_JP2},
        {"jpm ", EXT_JPM}, {"jpx ", EXT_JPX}, {"KDDI", EXT_3GP},
        {"M4A ", EXT_M4A}, {"M4B ", EXT_M4B}, {"M4P ", EXT_M4P},
        {"M4V ", EXT_M4V}, {"M4VH", EXT_M4V}, {"M4VP", EXT_M4V},
        {"mj2s", EXT_JP2}, {"mjp2", EXT_JP2}, {"mmp4", EXT_MP4},
        {"mp21", EXT_MP4}, {"mp41", EXT_MP4}, {"mp42", EXT_MP4},
        {"mp71", EXT_MP4}, {"MPPI", EXT_MP4}, {"mqt ", EXT_MQV},
        {"MSNV", EXT_MP4}, {"NDAS", EXT_MP4}, {"NDSC", EXT_MP4},
        {"NDSH", EXT_MP4}, {"NDSM", EXT_MP4}, {"NDSP", EXT_MP4},
        {"NDSS", EXT_MP4}, {"NDXC", EXT_MP4}, {"NDXH", EXT_MP4},
        {"NDXM", EXT_MP4}, {"NDXP", EXT_MP4}, {"NDXS", EXT_MP4},
        {"odcf", EXT_MP4}, {"opf2", EXT_MP4}, {"opx2", EXT_MP4},
        {"pana", EXT_MP4}, {"qt  ", EXT_MOV}, {"ROSS", EXT_MP4},
        {"sdv ", EXT_MP4}, {"ssc1", EXT_MP4}, {"ssc2", EXT_MP4}
    };

    // Box types the walk accepts after the ftyp box
    localparam logic [31:0] WALK_TYPES [7] = '{
        BOX_FTYP, BOX_MOOV, BOX_MDAT, BOX_FREE, BOX_SKIP, BOX_WIDE, BOX_PNOT
    };

    // Directed rows: one stream byte, plus a hand-written verdict where it is obvious
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;   // 1: check against want instead of the parser model
        mfd_result_t want;
    } dir_row_t;

    localparam logic [39:0] MID_BYTE = '0;   // not last, nothing typed

    localparam dir_row_t DIR_PLAN [26] = '{
        // single-byte streams at both data extremes: never a file
        {8'h00, 1'b1, 1'b1, 1'b0, 32'd0, EXT_MP4},
        {8'hFF, 1'b1, 1'b1, 1'b0, 32'd0, EXT_MP4},
        // minimal file: 16-byte ftyp box, major brand isom, stream ends with the box
        {8'h00, MID_BYTE}, {8'h00, MID_BYTE}, {8'h00, MID_BYTE}, {8'h10, MID_BYTE},
        {"f", MID_BYTE}, {"t", MID_BYTE}, {"y", MID_BYTE}, {"p", MID_BYTE},
        {"i", MID_BYTE}, {"s", MID_BYTE}, {"o", MID_BYTE}, {"m", MID_BYTE},
        {8'h00, MID_BYTE}, {8'h00, MID_BYTE}, {8'h02, MID_BYTE},
        {8'h00, 1'b1, 1'b1, 1'b1, 32'd16, EXT_MP4},
        // maximal box size but only 8 bytes in the stream: too short to be a file
        {8'hFF, MID_BYTE}, {8'hFF, MID_BYTE}, {8'hFF, MID_BYTE}, {8'hFF, MID_BYTE},
        {"f", MID_BYTE}, {"t", MID_BYTE}, {"y", MID_BYTE},
        {"p", 1'b1, 1'b1, 1'b0, 32'd0, EXT_MP4}
    };

    typedef enum logic [1:0] {
        SCAN_HEADER,
        SCAN_BOXES,
        SCAN_HELD,
        SCAN_DONE
    } scan_phase_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_is_file;
    logic [31:0] m_file_length;
    logic [4:0]  m_ext_code;

    mp4_file_detector #(
        .HEADER_SIZE (HEADER_SIZE_DEF),
        .LENGTH_BITS (LENGTH_BITS_DEF)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_file     (m_is_file),
        .m_file_length (m_file_length),
        .m_ext_code    (m_ext_code)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    mfd_result_t verdicts_due [$];   // expected verdicts, oldest first
    logic [7:0]  stream_buf [$];     // bytes of the stream being built

    int  bytes_sent       = 0;
    int  stream_count     = 0;
    int  verdicts_checked = 0;
    int  files_seen       = 0;
    int  err_count        = 0;
    bit  burst_mode       = 1'b0;    // both sides run without idle cycles
    bit  hold_out_req     = 1'b0;    // asks the receiver for one long hold-off

    // ------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------
    longint unsigned trk_pos, trk_ftyp_end, trk_box_start;
    logic [31:0]     trk_word, trk_box_size;
    scan_phase_t     trk_phase;
    logic [4:0]      trk_ext;
    bit              trk_ext_ok, trk_reject;

    function automatic void clear_tracker();
        trk_pos       = 0;
        trk_ftyp_end  = 0;
        trk_box_start = 0;
        trk_word      = '0;
        trk_box_size  = '0;
        trk_phase     = SCAN_HEADER;
        trk_ext       = EXT_MP4;
        trk_ext_ok    = 1'b0;
        trk_reject    = 1'b0;
    endfunction

    function automatic longint unsigned add_clamped(input longint unsigned a,
                                                    input longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > LEN_MAX) ? LEN_MAX : s;
    endfunction

    function automatic void match_brand(input logic [31:0] w);
        for (int i = 0; i < N_BRANDS; i++) begin
            if (BRANDS[i][36:5] == w) begin
                trk_ext    = BRANDS[i][4:0];
                trk_ext_ok = 1'b1;
                return;
            end
        end
    endfunction

    function automatic bit walk_type_ok(input logic [31:0] w);
        foreach (WALK_TYPES[i]) begin
            if (WALK_TYPES[i] == w) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the model by one accepted byte; returns 1 with the verdict on a last byte.
    function automatic bit track_byte(input logic [7:0] b, input logic l,
                                      output mfd_result_t verdict);
        longint unsigned brand_at, offset, span;
        bit              is_f;
        verdict = '0;
        // a held box header is applied one byte late, so a header that ends the
        // stream never moves the end of the walk
        if (trk_phase == SCAN_HELD) begin
            trk_box_start = add_clamped(trk_box_start, trk_box_size);
            trk_phase     = SCAN_BOXES;
        end
        trk_word = {trk_word[23:0], b};

        if (trk_pos < LEN_MAX) begin
            if (trk_pos == 3) begin
                trk_ftyp_end  = trk_word;
                trk_box_start = trk_word;
                if (trk_word < HEADER_SIZE_DEF) trk_reject = 1'b1;
            end
            if (trk_pos == 7) begin
                if (trk_word != BOX_FTYP) trk_reject = 1'b1;
                else if (!trk_reject) trk_phase = SCAN_BOXES;
            end
            if (trk_pos == 11 && !trk_reject) match_brand(trk_word);
            // compatible brands: aligned words starting inside the ftyp box
            if (trk_pos >= BRAND_BASE + 3 && !trk_ext_ok && !trk_reject) begin
                brand_at = trk_pos - 3;
                if (((brand_at - BRAND_BASE) & 3) == 0 && brand_at < trk_ftyp_end &&
                    trk_word != 0) begin
                    match_brand(trk_word);
                end
            end
            if (trk_phase == SCAN_BOXES && trk_pos >= trk_box_start) begin
                offset = trk_pos - trk_box_start;
                if (offset == 3) begin
                    trk_box_size = trk_word;
                end else if (offset == 7) begin
                    if (trk_box_size < MIN_BOX || !walk_type_ok(trk_word)) trk_phase = SCAN_DONE;
                    else trk_phase = SCAN_HELD;
                end
            end
        end
        trk_pos = add_clamped(trk_pos, 1);

        if (!l) return 1'b0;

        is_f = !trk_reject && trk_ext_ok && trk_pos >= HEADER_SIZE_DEF;
        span = (trk_box_start < trk_pos) ? trk_box_start : trk_pos;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        verdict.is_file     = is_f;
        verdict.file_length = is_f ? span[31:0] : 32'd0;
        verdict.ext_code    = is_f ? trk_ext : EXT_MP4;
        clear_tracker();   // next byte opens a new stream
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers one byte, waits for the handshake, feeds the model
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic l,
                             input logic typed, input mfd_result_t typed_want);
        int          gap;
        mfd_result_t v;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= l;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (track_byte(b, l, v)) begin
            verdicts_due.push_back(typed ? typed_want : v);
            stream_count++;
        end
        @(negedge aclk);
    endtask

    task automatic send_stream(input bit steady);
        burst_mode = steady;
        foreach (stream_buf[i]) push_byte(stream_buf[i], i == stream_buf.size() - 1, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Stream generator
    // ------------------------------------------------------------------
    task automatic put_word(input logic [31:0] w);
        stream_buf.push_back(w[31:24]);
        stream_buf.push_back(w[23:16]);
        stream_buf.push_back(w[15:8]);
        stream_buf.push_back(w[7:0]);
    endtask

    task automatic put_noise(input int n);
        repeat (n) stream_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // brand-like word: zero, a listed brand, or anything
    function automatic logic [31:0] pick_word(input int unsigned zero_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return 32'd0;
        if (r < zero_pct + 45) return BRANDS[$urandom_range(0, N_BRANDS - 1)][36:5];
        return $urandom;
    endfunction

    task automatic build_stream();
        int unsigned ftyp_size, content, bsize, kind, cut_at, hdr_end;
        logic [31:0] w;
        stream_buf.delete();
        hdr_end = 0;
        if ($urandom_range(0, 4) == 0) begin
            put_noise($urandom_range(1, 24));
            return;
        end
        // ftyp box: mostly sane, some unaligned, too small, or far past the stream
        kind = $urandom_range(0, 9);
        if (kind < 7)       ftyp_size = 16 + 4 * $urandom_range(0, 5);
        else if (kind == 7) ftyp_size = $urandom_range(16, 40);
        else if (kind == 8) ftyp_size = $urandom_range(0, 15);
        else                ftyp_size = $urandom | 32'h0100_0000;
        put_word(ftyp_size);
        kind = $urandom_range(0, 19);
        if (kind == 0)      put_word($urandom);
        else if (kind == 1) put_word(BOX_FTYP ^ (32'd1 << $urandom_range(0, 31)));
        else                put_word(BOX_FTYP);
        put_word(pick_word(0));     // major brand
        put_word($urandom);         // minor version
        content = (ftyp_size >= 16 && ftyp_size <= 40) ? ftyp_size - 16 : $urandom_range(0, 20);
        while (content >= 4) begin
            put_word(pick_word(25));
            content -= 4;
        end
        put_noise(content);
        // following boxes, only while the ftyp box fits in the stream
        if (ftyp_size <= 40) begin
            repeat ($urandom_range(0, 3)) begin
                kind  = $urandom_range(0, 19);
                bsize = $urandom_range(8, 20);
                w     = WALK_TYPES[$urandom_range(0, 6)];
                if (kind == 0)      bsize = $urandom_range(0, 7);
                else if (kind == 1) w = $urandom;
                else if (kind == 2) bsize = $urandom | 32'h8000_0000;   // can drive the sum to clamp
                put_word(bsize);
                put_word(w);
                if (hdr_end == 0) hdr_end = stream_buf.size();
                put_noise((bsize >= 8 && bsize <= 20) ? bsize - 8 : $urandom_range(0, 6));
            end
        end
        if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 3));
        // truncation: anywhere, or right where the first box header completes
        kind   = $urandom_range(0, 9);
        cut_at = stream_buf.size();
        if (kind < 2)                      cut_at = $urandom_range(1, stream_buf.size());
        else if (kind == 2 && hdr_end > 0) cut_at = hdr_end;
        while (stream_buf.size() > cut_at) void'(stream_buf.pop_back());
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t row;
        int       drain_cycles;
        clear_tracker();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows first; untyped rows are checked against the model
        for (int i = 0; i < 26; i++) begin
            row = DIR_PLAN[i];
            push_byte(row.data, row.last, row.typed, row.want);
        end

        while (bytes_sent < BYTES_WANTED || stream_count < STREAMS_WANTED) begin
            if (stream_count == PRESSURE_AT && !hold_out_req) begin
                // receiver goes quiet while short streams keep coming: the result
                // register and then the input register fill and s_ready drops
                hold_out_req = 1'b1;
                repeat (12) begin
                    stream_buf.delete();
                    put_noise($urandom_range(1, 2));
                    send_stream(1'b1);
                end
            end
            build_stream();
            send_stream($urandom_range(0, 4) == 0);
        end
        s_valid <= 1'b0;

        drain_cycles = 0;
        while (verdicts_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (10) @(posedge aclk);   // any stray verdict shows up here
        if (verdicts_due.size() != 0) begin
            $display("%0d verdicts never arrived", verdicts_due.size());
            err_count += verdicts_due.size();
        end

        $display("Sent %0d bytes in %0d streams; checked %0d verdicts, %0d of them files.",
                 bytes_sent, stream_count, verdicts_checked, files_seen);
        $display("Mismatches: %0d", err_count);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    initial begin : receiver
        int          gap;
        mfd_result_t want;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_out_req && verdicts_checked >= PRESSURE_AT - 1) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_out_req = 1'b0;
            end
            gap = burst_mode ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);

            verdicts_checked++;
            if (m_is_file) files_seen++;
            if (verdicts_due.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("verdict %0d arrived with none pending", verdicts_checked);
            end else begin
                want = verdicts_due.pop_front();
                if (m_is_file !== want.is_file || m_file_length !== want.file_length ||
                    m_ext_code !== want.ext_code) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("verdict %0d: is_file %0b/%0b length %0d/%0d ext %0d/%0d %s",
                                 verdicts_checked, want.is_file, m_is_file,
                                 want.file_length, m_file_length, want.ext_code, m_ext_code,
                                 "(expected/actual)");
                end
            end
            @(negedge aclk);
        end
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Timed out with %0d verdicts pending", verdicts_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
